// File: design/gnsf_pkg.sv
// Package: shared types, constants and parity helper for the subframe framer.
`default_nettype none
package gnsf_pkg;
	localparam logic [31:0] PREAMBLE_POS  = 32'h22c0_0000;
	localparam logic [31:0] DATA_FLIP     = 32'h3fff_ffc0;
	localparam logic [31:0] PREAMBLE_MASK = 32'h3fc0_0000;
	localparam logic [9:0]  FULL_MASK     = 10'h3ff;
	localparam logic [25:0] WEEK_M240     = 26'd30239760;
	localparam int          NUM_SF        = 5;

	typedef logic [31:0] pvec_t [6];
	localparam pvec_t PARITY_VEC = '{32'hbb1f3480, 32'h5d8f9a40, 32'haec7cd00,
		32'h5763e680, 32'h6bb1f340, 32'h8b7a89c0};

	typedef enum logic [2:0] {
		EV_NONE   = 3'd0,
		EV_SYNC   = 3'd1,
		EV_REJECT = 3'd2,
		EV_WORD   = 3'd3,
		EV_PFAIL  = 3'd4
	} event_t;

	typedef struct packed {
		logic [3:0]  out_channel;
		event_t      event_res;
		logic [23:0] word_data;
		logic [3:0]  word_index;
		logic [2:0]  subframe_id;
		logic [16:0] tow;
		logic        time_load;
		logic [25:0] bit_time;
		logic        epoch_sync;
		logic        subframe_done;
		logic        subframe_good;
	} result_t;

	// GPS parity check of one 32-bit window (D29*, D30* in the two top bits)
	function automatic logic word_ok(input logic [31:0] w);
		logic [5:0] calc;
		for (int i = 0; i < 6; i++) begin
			calc[5 - i] = ^(w & PARITY_VEC[i]);
		end
		return w[5:0] == calc;
	endfunction
endpackage
`default_nettype wire

// File: design/gnsf_tow_mul.sv
// TOW to bit-time conversion: TOW*300-240, week wrap when TOW is zero.
`default_nettype none
module gnsf_tow_mul (
	input  wire logic [16:0] tow,
	output logic [25:0]      bit_time
);
	import gnsf_pkg::*;
	logic [25:0] prod;

	// 300 = 256 + 32 + 8 + 4, shifts and adds
	assign prod = ({9'd0, tow} << 8) + ({9'd0, tow} << 5) + ({9'd0, tow} << 3)
		+ ({9'd0, tow} << 2);
	assign bit_time = (tow == 17'd0) ? WEEK_M240 : prod - 26'd240;
endmodule
`default_nettype wire

// File: design/gps_nav_subframe_framer.sv
// Top level: GPS LNAV subframe framer, per-channel sync, parity and TOW check.
// Usage:
//  Input channel: valid/ready with fields channel and nav_bit, one data bit of
//  one tracking channel per beat. Output channel: valid/ready, exactly one
//  result beat per input beat, in order.
//  Each result is registered, or parked in the skid, before it is offered.
//  Throughput: one beat per cycle while ready; each beat reads and updates the
//  state of its channel in a single pass of logic between the input handshake
//  and the result register, so back-to-back beats of the same channel are
//  fine. The result register is followed by a one-entry skid buffer, so
//  in_ready only depends on the skid being empty; a stalled receiver holds
//  its beat and at most one further beat is buffered before in_ready drops.
//  Reset (arst_n low) clears all channel state, valid masks and TOWs; the
//  block is ready in the first cycle after reset.
//  Channels at or above NUM_CHANNELS change no state and give event 0.
`default_nettype none
module gps_nav_subframe_framer #(
	parameter int NUM_CHANNELS = 12
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [3:0]  channel,
	input  wire logic        nav_bit,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [3:0]       out_channel,
	output logic [2:0]       event_res,
	output logic [23:0]      word_data,
	output logic [3:0]       word_index,
	output logic [2:0]       subframe_id,
	output logic [16:0]      tow,
	output logic             time_load,
	output logic [25:0]      bit_time,
	output logic             epoch_sync,
	output logic             subframe_done,
	output logic             subframe_good
);
	import gnsf_pkg::*;

	localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	// per-channel state; masks and TOWs of all five subframes sit in one entry
	logic [31:0] recent_q [NUM_CHANNELS];
	logic [31:0] older_q  [NUM_CHANNELS];
	logic        synced_q [NUM_CHANNELS];
	logic        inv_q    [NUM_CHANNELS];
	logic [2:0]  sf_q     [NUM_CHANNELS];
	logic [4:0]  bitc_q   [NUM_CHANNELS];
	logic [3:0]  wordc_q  [NUM_CHANNELS];
	logic        epoch_q  [NUM_CHANNELS];
	logic [NUM_SF-1:0][9:0]  mask_q [NUM_CHANNELS];
	logic [NUM_SF-1:0][16:0] stow_q [NUM_CHANNELS];

	logic    accept, do_upd;
	logic    skid_v_q, res_v_q;
	result_t res_q, skid_q, res_d;
	logic [CH_W-1:0] ch;
	logic [CH_W-1:0] chc;
	logic [16:0] tow_c;
	logic [25:0] tib_c;

	// next-state values for the addressed channel
	logic [31:0] n_recent, n_older;
	logic        n_synced, n_inv, n_epoch, clr_all;
	logic [2:0]  n_sf;
	logic [4:0]  n_bitc;
	logic [3:0]  n_wordc;
	logic        wr_mask, wr_tow;
	logic [2:0]  wr_sf;
	logic [9:0]  wr_mask_val;

	assign in_ready = !skid_v_q;
	assign accept   = in_valid && in_ready;
	assign ch       = CH_W'(channel);
	assign do_upd   = accept && ({2'b0, channel} < 6'(NUM_CHANNELS));
	assign chc      = do_upd ? ch : '0;

	gnsf_tow_mul u_mul (.tow(tow_c), .bit_time(tib_c));

	// single-pass per-item logic
	always_comb begin
		logic        b, inv, idok;
		logic [31:0] r, tlm, how, w;
		logic [2:0]  id, prev, sf;
		logic [3:0]  wi, wn;
		logic [9:0]  m;
		res_d = '0;
		res_d.out_channel = channel;
		res_d.event_res = EV_NONE;
		n_recent = recent_q[chc]; n_older = older_q[chc];
		n_synced = synced_q[chc]; n_inv = inv_q[chc]; n_epoch = epoch_q[chc];
		n_sf = sf_q[chc]; n_bitc = bitc_q[chc]; n_wordc = wordc_q[chc];
		clr_all = 1'b0; wr_mask = 1'b0; wr_tow = 1'b0; wr_sf = '0; wr_mask_val = '0;
		tow_c = '0;
		b = nav_bit ^ (synced_q[chc] & inv_q[chc]);
		r = {recent_q[chc][30:0], b};
		n_older = {older_q[chc][30:0], r[30]};
		n_recent = r;
		tlm = n_older; how = r; inv = 1'b0;
		if (how[0]) begin
			tlm = ~tlm; how = ~how; inv = 1'b1;
		end
		if (tlm[30]) tlm = tlm ^ DATA_FLIP;
		if (how[30]) how = how ^ DATA_FLIP;
		id = how[10:8];
		idok = id >= 3'd1 && id <= 3'd5;
		prev = (id == 3'd1) ? 3'd4 : id - 3'd2;
		sf = (sf_q[chc] >= 3'd5) ? sf_q[chc] - 3'd5 : sf_q[chc];
		w = r;
		if (w[30]) w = w ^ DATA_FLIP;
		wi = wordc_q[chc];
		wn = wi + 4'd1;
		m = mask_q[chc][sf];
		if (!synced_q[chc]) begin
			if ((tlm & PREAMBLE_MASK) == PREAMBLE_POS && idok && how[1:0] == 2'b00
					&& word_ok(tlm) && word_ok(how)) begin
				n_synced = 1'b1;
				n_sf = id - 3'd1;
				n_inv = inv;
				if (inv) n_recent = ~r;
				n_wordc = 4'd2;
				n_bitc = 5'd0;
				wr_mask = 1'b1; wr_tow = 1'b1; wr_sf = id - 3'd1; wr_mask_val = 10'd3;
				res_d.event_res = EV_SYNC;
				res_d.word_data = how[29:6];
				res_d.word_index = 4'd1;
				res_d.subframe_id = id - 3'd1;
				res_d.tow = how[29:13];
				tow_c = how[29:13];
				if (mask_q[chc][prev][1:0] != 2'b00) begin
					if ({1'b0, how[29:13]} != {1'b0, stow_q[chc][prev]} + 18'd1) begin
						clr_all = 1'b1;
						n_synced = 1'b0; n_sf = '0; n_epoch = 1'b0;
						res_d.event_res = EV_REJECT;
					end else begin
						res_d.time_load = 1'b1;
						res_d.bit_time = tib_c;
						if (!epoch_q[chc]) begin
							res_d.epoch_sync = 1'b1;
							n_epoch = 1'b1;
						end
					end
				end
			end
		end else begin
			n_bitc = bitc_q[chc] + 5'd1;
			if (n_bitc >= 5'd30) begin
				n_bitc = 5'd0;
				n_recent = w;
				if (word_ok(w)) begin
					res_d.event_res = EV_WORD;
					res_d.word_data = w[29:6];
					if (wi < 4'd10) begin
						m = m | (10'd1 << wi);
						wr_mask = 1'b1; wr_sf = sf; wr_mask_val = m;
					end
				end else begin
					res_d.event_res = EV_PFAIL;
				end
				res_d.word_index = wi;
				res_d.subframe_id = sf;
				res_d.tow = stow_q[chc][sf];
				n_wordc = wn;
				if (wn >= 4'd10) begin
					n_synced = 1'b0;
					if (inv_q[chc]) n_recent = ~w;
					res_d.subframe_done = 1'b1;
					res_d.subframe_good = (m == FULL_MASK);
				end
			end
		end
		if (!do_upd) begin
			res_d = '0;
			res_d.out_channel = channel;
		end
	end

	// channel state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				recent_q[c] <= '0; older_q[c] <= '0; synced_q[c] <= 1'b0;
				inv_q[c] <= 1'b0; sf_q[c] <= '0; bitc_q[c] <= '0;
				wordc_q[c] <= '0; epoch_q[c] <= 1'b0;
				mask_q[c] <= '0; stow_q[c] <= '0;
			end
		end else if (do_upd) begin
			recent_q[chc] <= n_recent; older_q[chc] <= n_older;
			synced_q[chc] <= n_synced; inv_q[chc] <= n_inv; sf_q[chc] <= n_sf;
			bitc_q[chc] <= n_bitc; wordc_q[chc] <= n_wordc; epoch_q[chc] <= n_epoch;
			if (wr_tow) stow_q[chc][wr_sf] <= tow_c;
			if (clr_all) begin
				mask_q[chc] <= '0;
			end else if (wr_mask) begin
				mask_q[chc][wr_sf] <= wr_mask_val;
			end
		end
	end

	// result register with skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (res_v_q && !out_ready && accept) skid_v_q <= 1'b1;
			else if (out_ready) skid_v_q <= 1'b0;
			if (out_ready || !res_v_q) res_v_q <= accept || skid_v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (res_v_q && !out_ready && accept) skid_q <= res_d;
		if (out_ready || !res_v_q) res_q <= skid_v_q ? skid_q : res_d;
	end

	assign out_valid     = res_v_q;
	assign out_channel   = res_q.out_channel;
	assign event_res     = res_q.event_res;
	assign word_data     = res_q.word_data;
	assign word_index    = res_q.word_index;
	assign subframe_id   = res_q.subframe_id;
	assign tow           = res_q.tow;
	assign time_load     = res_q.time_load;
	assign bit_time      = res_q.bit_time;
	assign epoch_sync    = res_q.epoch_sync;
	assign subframe_done = res_q.subframe_done;
	assign subframe_good = res_q.subframe_good;

	// skid only fills while the output is stalled
	a_skid: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> res_v_q) else $error("skid full without result");
	// good only with done
	a_good: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && subframe_good |-> subframe_done) else $error("good without done");
	// time load only on sync
	a_tl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && time_load |-> event_res == EV_SYNC) else $error("bad time load");
endmodule
`default_nettype wire
